FILE: rtl/core/rvexe_pkg.sv
// Package for the RV32I subset execute core: opcodes, funct codes and the
// per-item execute result struct. No dependencies.
package rvexe_pkg;

  localparam logic [6:0] OPC_HALT  = 7'b0000000;
  localparam logic [6:0] OPC_R     = 7'b0110011;
  localparam logic [6:0] OPC_I     = 7'b0010011;
  localparam logic [6:0] OPC_LOAD  = 7'b0000011;
  localparam logic [6:0] OPC_STORE = 7'b0100011;

  localparam logic [6:0] F7_ADD = 7'b0000000;
  localparam logic [6:0] F7_SUB = 7'b0100000;

  localparam logic [2:0] F3_ADD = 3'b000;
  localparam logic [2:0] F3_OR  = 3'b110;
  localparam logic [2:0] F3_AND = 3'b111;

  localparam int unsigned RESULT_BITS = 80;

  typedef struct packed {
    logic        halted;
    logic        wr;     // register write, already dropped for x0
    logic        ld;
    logic        st;
    logic [4:0]  rd;     // zero unless wr
    logic [31:0] val;    // ALU result, zero for loads
    logic [31:0] addr;   // rs1 + imm for load/store, else zero
    logic [31:0] sval;   // store data, else zero
  } exec_t;

endpackage

FILE: rtl/core/rv32i_subset_execute_core.sv
// Top level of the RV32I subset execute core: register file, banked data
// memory, forwarding and output skid buffer. Depends on rvexe_pkg,
// rvexe_ram and rvexe_exec.
//
// Usage:
//   Input channel s_*: one 32-bit instruction per item on s_tdata.
//   Output channel m_*: one result item per instruction on m_tdata.
//   Supported: ADD SUB AND OR ADDI ANDI ORI LW SW. Opcode zero reports
//   halted; branches and unknown encodings produce an all-zero result.
//   Pipeline: operands are read on the edge that accepts the instruction,
//   then execute/memory into stage 2, then writeback into the output register.
//   Throughput: one item per cycle; the pipeline only stops when both the
//   output register and the skid register are full.
//   Reset: register file reads zero at once (valid bits); the data memory
//   is swept to zero, one row of all four byte banks per cycle, with
//   s_tready low until the sweep is done.
//   Stall: a stalled output keeps m_tdata steady; one more result is
//   parked in the skid register, then s_tready drops until it drains.
//   DATA_BYTES must be a power of two; addresses wrap modulo DATA_BYTES.
module rv32i_subset_execute_core
  import rvexe_pkg::*;
#(
  parameter int unsigned DATA_BYTES = 128
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [31:0]            s_tdata,  // [31:0] instruction_word
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // m_tdata from bit 0: halted, writes_register, dest_register[4:0],
  // write_value[31:0], stores_memory, mem_address[6:0], store_value[31:0], pad
  output logic [RESULT_BITS-1:0] m_tdata
);

  localparam int unsigned ADDR_W = $clog2(DATA_BYTES);
  localparam int unsigned ROWS   = DATA_BYTES / 4;
  localparam int unsigned ROW_W  = ADDR_W - 2;

  // ---------------------------------------------------------------- control
  logic             en;        // pipeline advance
  logic             in_acc;
  logic             clr_busy;
  logic [ROW_W-1:0] clr_row;

  logic                   out_v;
  logic [RESULT_BITS-1:0] out_d;
  logic                   skid_v;
  logic [RESULT_BITS-1:0] skid_d;

  assign en       = !skid_v;
  assign s_tready = en && !clr_busy;
  assign in_acc   = s_tvalid && s_tready;
  assign m_tvalid = out_v;
  assign m_tdata  = out_d;

  // data memory clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_row  <= '0;
    end else if (clr_busy) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == ROW_W'(ROWS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------- stage 1: read
  logic        v1;
  logic [31:0] instr1;
  logic        va1;
  logic        vb1;
  logic [31:0] qa;
  logic [31:0] qb;
  logic [31:0] rf_valid;

  // stage 2 / writeback signals used for forwarding
  logic        v2;
  exec_t       ex2;
  logic [1:0]  lo2;
  logic [31:0] val2;
  logic        rf_we;
  logic        wb_v;
  logic [4:0]  wb_rd;
  logic [31:0] wb_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      instr1 <= s_tdata;
      va1    <= rf_valid[s_tdata[19:15]];
      vb1    <= rf_valid[s_tdata[24:20]];
    end
  end

  // two copies of the register file, one per read port
  rvexe_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (ex2.rd),
    .wdata (val2),
    .re    (in_acc),
    .raddr (s_tdata[19:15]),
    .rdata (qa)
  );

  rvexe_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (ex2.rd),
    .wdata (val2),
    .re    (in_acc),
    .raddr (s_tdata[24:20]),
    .rdata (qb)
  );

  // operand forwarding: stage 2 result first, then the write that
  // landed on the same edge as the RAM read, then the RAM itself
  logic [4:0]  rs1;
  logic [4:0]  rs2;
  logic [31:0] a1;
  logic [31:0] b1;

  assign rs1 = instr1[19:15];
  assign rs2 = instr1[24:20];

  always_comb begin
    if (rs1 == 5'd0) begin
      a1 = '0;
    end else if (v2 && ex2.wr && ex2.rd == rs1) begin
      a1 = val2;
    end else if (wb_v && wb_rd == rs1) begin
      a1 = wb_val;
    end else begin
      a1 = va1 ? qa : '0;
    end
    if (rs2 == 5'd0) begin
      b1 = '0;
    end else if (v2 && ex2.wr && ex2.rd == rs2) begin
      b1 = val2;
    end else if (wb_v && wb_rd == rs2) begin
      b1 = wb_val;
    end else begin
      b1 = vb1 ? qb : '0;
    end
  end

  // ------------------------------------------------------ stage 1: execute
  exec_t ex1;

  rvexe_exec u_exec (
    .instr (instr1),
    .a     (a1),
    .b     (b1),
    .ex    (ex1)
  );

  logic [ADDR_W-1:0] byte_addr;
  logic [1:0]        lo1;
  logic [ROW_W-1:0]  row1;

  assign byte_addr = ex1.addr[ADDR_W-1:0];
  assign lo1       = byte_addr[1:0];
  assign row1      = byte_addr[ADDR_W-1:2];

  // four byte banks; bank k holds addresses with low bits k
  logic [7:0] bank_q [4];

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [1:0]       idx;       // which byte of the word lands here
    logic [ROW_W-1:0] row_k;
    logic [7:0]       st_byte;
    logic             we_k;
    logic [ROW_W-1:0] addr_k;

    assign idx     = 2'(k) - lo1;
    assign row_k   = (2'(k) >= lo1) ? row1 : row1 + 1'b1;
    assign st_byte = 8'(ex1.sval >> {idx, 3'b000});
    assign we_k    = clr_busy || (en && v1 && ex1.st);
    assign addr_k  = clr_busy ? clr_row : row_k;

    rvexe_ram #(.WIDTH(8), .DEPTH(ROWS)) u_mem (
      .clk   (clk),
      .we    (we_k),
      .waddr (addr_k),
      .wdata (clr_busy ? 8'h00 : st_byte),
      .re    (en && v1 && ex1.ld),
      .raddr (row_k),
      .rdata (bank_q[k])
    );
  end

  // ---------------------------------------------------- stage 2: writeback
  exec_t ex1_w;   // execute result with the address wrapped to memory size

  always_comb begin
    ex1_w      = ex1;
    ex1_w.addr = 32'(byte_addr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v1) begin
      ex2 <= ex1_w;
      lo2 <= lo1;
    end
  end

  logic [31:0] ld_word;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ld_word[8*i +: 8] = bank_q[lo2 + 2'(i)];
    end
  end

  assign val2  = ex2.ld ? (ex2.wr ? ld_word : '0) : ex2.val;
  assign rf_we = en && v2 && ex2.wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
    end else if (rf_we) begin
      rf_valid[ex2.rd] <= 1'b1;
    end
  end

  // last register write, seen by the item whose read shared its edge
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_v <= 1'b0;
    end else if (en) begin
      wb_v <= v2 && ex2.wr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wb_rd  <= ex2.rd;
      wb_val <= val2;
    end
  end

  // ------------------------------------------------ output register + skid
  logic [RESULT_BITS-1:0] res2;
  logic                   res_in;

  assign res2 = {1'b0, ex2.sval, ex2.addr[6:0], ex2.st, val2, ex2.rd, ex2.wr,
                 ex2.halted};
  assign res_in = en && v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (!out_v || m_tready) begin
        if (skid_v) begin
          out_v  <= 1'b1;
          skid_v <= 1'b0;
        end else begin
          out_v <= res_in;
        end
      end else if (res_in) begin
        skid_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || m_tready) begin
      if (skid_v) begin
        out_d <= skid_d;
      end else if (res_in) begin
        out_d <= res2;
      end
    end else if (res_in) begin
      skid_d <= res2;
    end
  end

endmodule

FILE: rtl/core/rvexe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rvexe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/rvexe_exec.sv
// Decode and ALU for one instruction given its forwarded operands.
// Depends on rvexe_pkg.
module rvexe_exec
  import rvexe_pkg::*;
(
  input  logic [31:0] instr,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output exec_t       ex
);

  logic [6:0]  opc;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;

  assign opc   = instr[6:0];
  assign rd    = instr[11:7];
  assign f3    = instr[14:12];
  assign f7    = instr[31:25];
  assign imm_i = {{20{instr[31]}}, instr[31:20]};
  assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};

  always_comb begin
    ex = '0;
    case (opc)
      OPC_HALT: begin
        ex.halted = 1'b1;
      end
      OPC_R: begin
        if (f3 == F3_ADD && f7 == F7_ADD) begin
          ex.val = a + b;
          ex.wr  = 1'b1;
        end else if (f3 == F3_ADD && f7 == F7_SUB) begin
          ex.val = a - b;
          ex.wr  = 1'b1;
        end else if (f3 == F3_OR) begin
          ex.val = a | b;
          ex.wr  = 1'b1;
        end else if (f3 == F3_AND) begin
          ex.val = a & b;
          ex.wr  = 1'b1;
        end
      end
      OPC_I: begin
        if (f3 == F3_ADD) begin
          ex.val = a + imm_i;
          ex.wr  = 1'b1;
        end else if (f3 == F3_OR) begin
          ex.val = a | imm_i;
          ex.wr  = 1'b1;
        end else if (f3 == F3_AND) begin
          ex.val = a & imm_i;
          ex.wr  = 1'b1;
        end
      end
      OPC_LOAD: begin
        ex.addr = a + imm_i;
        ex.ld   = 1'b1;
        ex.wr   = 1'b1;
      end
      OPC_STORE: begin
        ex.addr = a + imm_s;
        ex.st   = 1'b1;
        ex.sval = b;
      end
      default: begin
        ex = '0;
      end
    endcase
    // x0 writes vanish
    if (ex.wr && rd != 5'd0) begin
      ex.rd = rd;
    end else begin
      ex.wr  = 1'b0;
      ex.val = '0;
      ex.rd  = '0;
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for rv32i_subset_execute_core: streams instructions in, predicts
// register file and data memory effects, and checks every result item. Depends on rvexe_pkg.
module testbench;
  import rvexe_pkg::*;

  localparam int unsigned MEM_BYTES    = 128;
  localparam int unsigned MEM_AW       = $clog2(MEM_BYTES);
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned HOLD_CYCLES  = 80;

  // Encodings outside the package's set.
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [2:0] F3_WORD    = 3'b010;   // lw / sw width code
  localparam logic [2:0] F3_SHIFT   = 3'b001;   // sll, not in the subset
  localparam logic [6:0] F7_MUL     = 7'b0000001; // M extension, not in the subset

  // One retired instruction as seen on m_tdata.
  typedef struct {
    logic        halted;
    logic        writes_register;
    logic [4:0]  dest_register;
    logic [31:0] write_value;
    logic        stores_memory;
    logic [6:0]  mem_address;
    logic [31:0] store_value;
  } retire_t;

  // Architectural model: register file, byte memory and the queue of
  // retire items still owed by the core.
  class execute_predictor;
    logic [31:0] regs[32];
    logic [7:0]  mem_bytes[MEM_BYTES];
    retire_t     pending_results[$];
    int unsigned mismatches;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (mem_bytes[i]) mem_bytes[i] = '0;
      mismatches = 0;
    endfunction

    // Executes one accepted instruction and queues its retire item.
    function void note_instruction(logic [31:0] word);
      logic [6:0]  opc;
      logic [4:0]  rd;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] imm_i;
      logic [31:0] imm_s;
      logic [31:0] addr;
      logic [31:0] val;
      logic        wr;
      retire_t     r;
      opc   = word[6:0];
      rd    = word[11:7];
      f3    = word[14:12];
      f7    = word[31:25];
      a     = regs[word[19:15]];   // x0 is never written, so it reads zero
      b     = regs[word[24:20]];
      imm_i = {{20{word[31]}}, word[31:20]};
      imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
      val   = '0;
      wr    = 1'b0;
      r     = '{default: '0};
      case (opc)
        OPC_HALT: r.halted = 1'b1;
        OPC_R: begin
          if (f3 == F3_ADD && f7 == F7_ADD) begin
            val = a + b; wr = 1'b1;
          end else if (f3 == F3_ADD && f7 == F7_SUB) begin
            val = a - b; wr = 1'b1;
          end else if (f3 == F3_OR) begin
            val = a | b; wr = 1'b1;
          end else if (f3 == F3_AND) begin
            val = a & b; wr = 1'b1;
          end
        end
        OPC_I: begin
          if (f3 == F3_ADD) begin
            val = a + imm_i; wr = 1'b1;
          end else if (f3 == F3_OR) begin
            val = a | imm_i; wr = 1'b1;
          end else if (f3 == F3_AND) begin
            val = a & imm_i; wr = 1'b1;
          end
        end
        OPC_LOAD: begin
          // any funct3 loads a full word; bytes wrap past the top
          addr = (a + imm_i) % MEM_BYTES;
          for (int i = 3; i >= 0; i--) begin
            val = {val[23:0], mem_bytes[MEM_AW'((addr + 32'(i)) % MEM_BYTES)]};
          end
          wr = 1'b1;
          r.mem_address = addr[6:0];
        end
        OPC_STORE: begin
          addr = (a + imm_s) % MEM_BYTES;
          for (int i = 0; i < 4; i++) begin
            mem_bytes[MEM_AW'((addr + 32'(i)) % MEM_BYTES)] = b[8*i +: 8];
          end
          r.stores_memory = 1'b1;
          r.mem_address   = addr[6:0];
          r.store_value   = b;
        end
        default: ;  // branches and unknown opcodes retire as all zero
      endcase
      // a write to x0 is dropped, but a load keeps its address
      if (wr && rd != 5'd0) begin
        regs[rd]          = val;
        r.writes_register = 1'b1;
        r.dest_register   = rd;
        r.write_value     = val;
      end
      pending_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    // Checks one accepted result item against the oldest prediction.
    function void check_result(logic [RESULT_BITS-1:0] data);
      retire_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, data);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("halted",          32'(want.halted),          32'(data[0]));
      compare_field("writes_register", 32'(want.writes_register), 32'(data[1]));
      compare_field("dest_register",   32'(want.dest_register),   32'(data[6:2]));
      compare_field("write_value",     want.write_value,          data[38:7]);
      compare_field("stores_memory",   32'(want.stores_memory),   32'(data[39]));
      compare_field("mem_address",     32'(want.mem_address),     32'(data[46:40]));
      compare_field("store_value",     want.store_value,          data[78:47]);
    endfunction
  endclass

  logic                   clk;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [31:0]            s_tdata  = '0;  // [31:0] instruction_word
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // halted, writes_register, dest_register, write_value, stores_memory,
  // mem_address, store_value, pad (from bit 0)
  logic [RESULT_BITS-1:0] m_tdata;

  execute_predictor predictor = new();

  rv32i_subset_execute_core #(
    .DATA_BYTES(MEM_BYTES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #200000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OPC_R};
  endfunction

  function automatic logic [31:0] enc_i(logic [6:0] opc, logic [11:0] imm, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1);
    return {imm[11:5], rs2, rs1, F3_WORD, imm[4:0], OPC_STORE};
  endfunction

  // Offers one instruction, optionally after a one-cycle gap, and holds it
  // until the core takes it. Valid stays high between back-to-back items.
  task automatic send_instruction(input logic [31:0] word, input bit may_idle);
    if (may_idle && $urandom_range(0, 99) < 12) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predictor.note_instruction(word);
  endtask

  // Result side: random stalls, one long hold-off so the output and skid
  // registers fill and s_tready drops, and a window with no stalls at all.
  initial begin
    int unsigned results;
    bit          ready_now;
    bit          held;
    results = 0;
    held    = 1'b0;
    forever begin
      if (results == 120 && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      ready_now = (results >= 250 && results < 350) ? 1'b1 : ($urandom_range(0, 99) >= 12);
      m_tready <= ready_now;
      @(posedge clk);
      if (ready_now && m_tvalid) begin
        predictor.check_result(m_tdata);
        results++;
      end
    end
  end

  initial begin
    logic [31:0] directed_words[$];
    logic [31:0] word;
    int unsigned kind;
    int unsigned sel;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: immediate extremes, every operation, x0 writes, address wrap,
    // halt, branch, unknown opcodes and encodings outside the subset.
    directed_words.push_back(enc_i(OPC_I, 12'h7FF, 5'd0, F3_ADD, 5'd1));     // addi max
    directed_words.push_back(enc_i(OPC_I, 12'h800, 5'd0, F3_ADD, 5'd2));     // addi min
    directed_words.push_back(enc_i(OPC_I, 12'hFFF, 5'd1, F3_ADD, 5'd3));     // addi -1
    directed_words.push_back(enc_r(F7_ADD, 5'd2, 5'd1, F3_ADD, 5'd4));
    directed_words.push_back(enc_r(F7_SUB, 5'd1, 5'd2, F3_ADD, 5'd5));
    directed_words.push_back(enc_r(F7_SUB, 5'd3, 5'd0, F3_ADD, 5'd6));
    directed_words.push_back(enc_r(F7_ADD, 5'd2, 5'd1, F3_OR, 5'd7));
    directed_words.push_back(enc_r(F7_ADD, 5'd2, 5'd3, F3_AND, 5'd8));
    directed_words.push_back(enc_i(OPC_I, 12'h555, 5'd2, F3_OR, 5'd9));
    directed_words.push_back(enc_i(OPC_I, 12'hAAA, 5'd3, F3_AND, 5'd10));
    directed_words.push_back(enc_r(F7_ADD, 5'd6, 5'd5, F3_ADD, 5'd31));
    directed_words.push_back(enc_s(12'd126, 5'd31, 5'd0));                    // wraps past top
    directed_words.push_back(enc_i(OPC_LOAD, 12'd126, 5'd0, F3_WORD, 5'd11));
    directed_words.push_back(enc_s(12'h7FF, 5'd4, 5'd2));                     // negative base
    directed_words.push_back(enc_i(OPC_LOAD, 12'h7FF, 5'd2, 3'b111, 5'd12));  // odd funct3
    directed_words.push_back(enc_i(OPC_LOAD, 12'd126, 5'd0, F3_WORD, 5'd0));  // load to x0
    directed_words.push_back(enc_i(OPC_I, 12'd5, 5'd1, F3_ADD, 5'd0));        // addi to x0
    directed_words.push_back(enc_s(12'hFFF, 5'd0, 5'd0));                     // store zero at top
    directed_words.push_back(32'hFFFF_FF80);                                  // halt, other bits set
    directed_words.push_back(32'h0000_0000);                                  // halt
    directed_words.push_back({25'h1FF_FFFF, OPC_BRANCH});
    directed_words.push_back(32'hFFFF_FFFF);                                  // unknown opcode
    directed_words.push_back(enc_r(F7_ADD, 5'd2, 5'd1, F3_SHIFT, 5'd13));
    directed_words.push_back(enc_r(F7_MUL, 5'd2, 5'd1, F3_ADD, 5'd14));
    directed_words.push_back(enc_i(OPC_I, 12'h123, 5'd1, F3_WORD, 5'd15));
    foreach (directed_words[i]) send_instruction(directed_words[i], 1'b1);

    // Random: mostly legal subset instructions with random registers and
    // immediates, plus halts, branches and raw noise. Items 250..349 go
    // back to back.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      word = $urandom();
      kind = $urandom_range(0, 99);
      sel  = $urandom_range(0, 4);
      if (kind < 22) begin
        word[6:0] = OPC_R;
        case (sel)
          0: begin
            word[14:12] = F3_ADD;
            word[31:25] = F7_ADD;
          end
          1: begin
            word[14:12] = F3_ADD;
            word[31:25] = F7_SUB;
          end
          2: word[14:12] = F3_OR;
          3: word[14:12] = F3_AND;
          default: ;
        endcase
      end else if (kind < 44) begin
        word[6:0] = OPC_I;
        case (sel)
          0: word[14:12] = F3_ADD;
          1: word[14:12] = F3_OR;
          2: word[14:12] = F3_AND;
          default: ;
        endcase
      end else if (kind < 62) begin
        word[6:0] = OPC_LOAD;
      end else if (kind < 82) begin
        word[6:0] = OPC_STORE;
      end else if (kind < 86) begin
        word[6:0] = OPC_HALT;
      end else if (kind < 90) begin
        word[6:0] = OPC_BRANCH;
      end
      send_instruction(word, n < 250 || n >= 350);
    end
    s_tvalid <= 1'b0;

    // Drain, then allow for the pipeline depth in case anything extra shows up.
    while (predictor.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (predictor.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
